/* rtl/core/multichannel_fractional_delay_line_defines.svh */
// Assertion shorthands; expect clk and arst_n in scope.
`ifndef MULTICHANNEL_FRACTIONAL_DELAY_LINE_DEFINES_SVH
`define MULTICHANNEL_FRACTIONAL_DELAY_LINE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MFDL_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define MFDL_ASSERT_IMP(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) else $error(msg);

`endif

/* rtl/core/mfdl_pkg.sv */
package mfdl_pkg;

	localparam int DEPTH       = 64;
	localparam int CHANNELS    = 13;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;

	localparam int CH_W     = 4;
	localparam int DLY_W    = 14;
	localparam int POS_W    = $clog2(DEPTH);
	localparam int WORDS    = CHANNELS * DEPTH;
	localparam int ADDR_W   = $clog2(WORDS);
	localparam int SPAN_M1  = DEPTH * (2 ** FRAC_BITS) - 1;
	localparam int DIFF_W   = SAMPLE_BITS + 1;
	localparam int PROD_W   = DIFF_W + FRAC_BITS + 1;

	localparam int S_DATA_W = ((CH_W + SAMPLE_BITS + DLY_W + 7) / 8) * 8;
	localparam int S_USER_W = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_ISSUE  = 3'b010,
		ST_SECOND = 3'b100
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic                 zero;
		logic [FRAC_BITS-1:0] frac;
	} interp_ctl_t;

endpackage

/* rtl/core/mfdl_interp.sv */
module mfdl_interp (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  mfdl_pkg::interp_ctl_t                      ctl,
	input  logic signed [mfdl_pkg::SAMPLE_BITS-1:0]    rdata,
	output logic                                       res_valid,
	output logic signed [mfdl_pkg::SAMPLE_BITS-1:0]    res_value
);
	import mfdl_pkg::*;

	interp_ctl_t                    ctl_s1, ctl_s2, ctl_s3;
	logic signed [SAMPLE_BITS-1:0]  a_s2, a_s3;
	logic signed [PROD_W-1:0]       prod_s3;
	logic signed [DIFF_W-1:0]       diff;
	logic signed [FRAC_BITS:0]      frac_s;
	logic signed [PROD_W-1:0]       shifted;
	logic signed [SAMPLE_BITS-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// rdata holds entry a in s1 and entry b in s2
	assign diff   = DIFF_W'(rdata) - DIFF_W'(a_s2);
	assign frac_s = signed'({1'b0, ctl_s2.frac});

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			a_s2 <= rdata;
		end
		if (ctl_s2.valid) begin
			a_s3    <= a_s2;
			prod_s3 <= diff * frac_s;
		end
	end

	// floor shift, then the sum always lands between a and b
	assign shifted   = prod_s3 >>> FRAC_BITS;
	assign sum       = a_s3 + signed'(shifted[SAMPLE_BITS-1:0]);
	assign res_valid = ctl_s3.valid;
	assign res_value = ctl_s3.zero ? '0 : sum;

endmodule

/* rtl/core/multichannel_fractional_delay_line.sv */
// Write beat: no result. Read beat: entries a and b come from the single-port
// sample memory on consecutive cycles (ST_ISSUE, then ST_SECOND), so no new beat
// is taken during a read's second access; writes one per cycle while s_tready is high.
// Read path: ctl passes mfdl_interp registers s1, s2 and s3; s3 pushes the result.
// Reset: write position goes to zero, then a clearing pass zeroes all 832 memory
// words; s_tready stays low until it finishes.
`include "multichannel_fractional_delay_line_defines.svh"

module multichannel_fractional_delay_line (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [3:0] channel, [19:4] sample_value, [33:20] delay, [39:34] zero
	input  logic [mfdl_pkg::S_DATA_W-1:0]   s_tdata,
	// [0] op_kind, [1] new_frame
	input  logic [mfdl_pkg::S_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] delayed_value
	output logic [mfdl_pkg::SAMPLE_BITS-1:0] m_tdata
);
	import mfdl_pkg::*;

	state_t                     state_q;
	logic [POS_W-1:0]           wpos_q;
	logic [ADDR_W-1:0]          clr_addr_q;
	logic [ADDR_W-1:0]          b_addr_q;
	logic [FCNT_W-1:0]          cnt_q;
	logic [FCNT_W-1:0]          fcnt_q;
	logic [FPTR_W-1:0]          wr_ptr_q, rd_ptr_q;
	logic [SAMPLE_BITS-1:0]     fifo_q [FIFO_DEPTH];

	logic signed [SAMPLE_BITS-1:0] mem [WORDS];
	logic signed [SAMPLE_BITS-1:0] rdata_q;

	op_kind_t                   op;
	logic [CH_W-1:0]            channel;
	logic                       new_frame;
	logic [SAMPLE_BITS-1:0]     sample_value;
	logic [DLY_W-1:0]           delay;

	logic                       acc, wr_acc, rd_acc, ch_ok, push, pop;
	logic [POS_W-1:0]           wpos_nxt, rd_i1, rd_i2;
	logic [ADDR_W-1:0]          base, mem_addr;
	logic                       mem_we, mem_re;
	logic signed [SAMPLE_BITS-1:0] mem_wdata;
	logic [31:0]                dly_sat;
	logic [POS_W-1:0]           d_int;
	logic [FRAC_BITS-1:0]       d_frac;
	logic [POS_W:0]             step, i1_wide;
	interp_ctl_t                ctl;
	logic                       res_valid;
	logic signed [SAMPLE_BITS-1:0] res_value;

	assign op           = op_kind_t'(s_tuser[0]);
	assign new_frame    = s_tuser[1];
	assign channel      = s_tdata[CH_W-1:0];
	assign sample_value = s_tdata[CH_W+SAMPLE_BITS-1:CH_W];
	assign delay        = s_tdata[CH_W+SAMPLE_BITS+DLY_W-1:CH_W+SAMPLE_BITS];

	assign s_tready = (state_q == ST_ISSUE) && (cnt_q < FCNT_W'(FIFO_DEPTH));
	assign acc      = s_tvalid && s_tready;
	assign wr_acc   = acc && (op == OP_WRITE);
	assign rd_acc   = acc && (op == OP_READ);
	assign ch_ok    = channel < CH_W'(CHANNELS);
	assign base     = ch_ok ? ADDR_W'(ADDR_W'(channel) * ADDR_W'(DEPTH)) : '0;

	assign wpos_nxt = !new_frame ? wpos_q :
	                  (wpos_q == POS_W'(DEPTH - 1)) ? '0 : wpos_q + 1'b1;

	// read point: integer part steps back one more when a fraction is left
	assign dly_sat = (32'(delay) > 32'(SPAN_M1)) ? 32'(SPAN_M1) : 32'(delay);
	assign d_int   = dly_sat[FRAC_BITS+POS_W-1:FRAC_BITS];
	assign d_frac  = dly_sat[FRAC_BITS-1:0];
	assign step    = (POS_W+1)'(d_int) + (POS_W+1)'(d_frac != '0);
	assign i1_wide = ((POS_W+1)'(wpos_q) >= step) ? (POS_W+1)'(wpos_q) - step
	                 : (POS_W+1)'(wpos_q) + (POS_W+1)'(DEPTH) - step;
	assign rd_i1   = i1_wide[POS_W-1:0];
	assign rd_i2   = (rd_i1 == POS_W'(DEPTH - 1)) ? '0 : rd_i1 + 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = base + ADDR_W'(rd_i1);
		mem_wdata = signed'(sample_value);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
			end
			ST_SECOND: begin
				mem_re   = 1'b1;
				mem_addr = b_addr_q;
			end
			ST_ISSUE: begin
				if (wr_acc) begin
					mem_we   = ch_ok;
					mem_addr = base + ADDR_W'(wpos_nxt);
				end else begin
					mem_re = rd_acc;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			b_addr_q <= base + ADDR_W'(rd_i2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			wpos_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(WORDS - 1)) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (wr_acc) begin
						wpos_q <= wpos_nxt;
					end
					if (rd_acc) begin
						state_q <= ST_SECOND;
					end
				end
				ST_SECOND: begin
					state_q <= ST_ISSUE;
				end
				default: begin
					state_q <= ST_ISSUE;
				end
			endcase
		end
	end

	assign ctl.valid = rd_acc;
	assign ctl.zero  = !ch_ok;
	assign ctl.frac  = -d_frac;

	mfdl_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rdata     (rdata_q),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	// result queue; cnt_q counts reads accepted and not yet delivered
	assign push     = res_valid;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = fcnt_q != '0;
	assign m_tdata  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			fcnt_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			cnt_q  <= cnt_q + FCNT_W'(rd_acc) - FCNT_W'(pop);
			fcnt_q <= fcnt_q + FCNT_W'(push) - FCNT_W'(pop);
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	`MFDL_ASSERT(a_queue_le_outstanding, fcnt_q <= cnt_q, "queue holds more than outstanding reads")
	`MFDL_ASSERT_IMP(a_no_push_full, push, fcnt_q < FCNT_W'(FIFO_DEPTH), "push into full queue")
	`MFDL_ASSERT_IMP(a_second_after_read, state_q == ST_SECOND, $past(rd_acc), "second read without read beat")
	`MFDL_ASSERT_IMP(a_idle_while_clear, state_q == ST_CLEAR, !s_tready && !mem_re, "access during clearing pass")

endmodule
